>>> rtl/iopq_pkg.sv
// Shared types and constants for the iteration-ordered priority queue.
// Used by iopq_ctrl, iopq_datapath and iteration_ordered_priority_queue.
`default_nettype none

package iopq_pkg;

   localparam int DEPTH        = 16;
   localparam int KEY_BITS     = 16;
   localparam int PAYLOAD_BITS = 16;
   localparam int COUNT_BITS   = $clog2(DEPTH + 1);

   localparam logic [1:0] ACT_PUT  = 2'd0;
   localparam logic [1:0] ACT_GET  = 2'd1;
   localparam logic [1:0] ACT_PEEK = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic {
      CTL_IDLE,
      CTL_RESPOND
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic push;       // insert the request entry in key order
      logic pop;        // drop the head, shift the rest up
      logic load_rsp;   // capture a new result
      logic show_head;  // result carries the head, else zeros
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;
      logic full;
   } dp_status_type;

endpackage

`default_nettype wire

>>> rtl/iteration_ordered_priority_queue.sv
// Top level of the iteration-ordered priority queue.
// Instantiates iopq_ctrl and iopq_datapath; depends on iopq_pkg.
//
// A bounded queue of 16 entries kept sorted by key, largest first, in a row
// of shift-register cells that each compare their own key in parallel. One
// item is taken per cycle: busy stays low, and the result of an item accepted
// at one clock edge is on the rsp_ ports, with rsp_strobe high, for exactly
// the following cycle. The receiver cannot stall, so it must take every
// result in that cycle. A put returns status success or full with zero key
// and payload; a get or peek returns the head, or status empty with zeros.
`default_nettype none

module iteration_ordered_priority_queue (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output      logic                              busy,
   input  wire logic [1:0]                        req_action,
   input  wire logic [iopq_pkg::KEY_BITS-1:0]     req_key_in,
   input  wire logic [iopq_pkg::PAYLOAD_BITS-1:0] req_payload_in,
   output      logic                              rsp_strobe,
   output      logic [1:0]                        rsp_status,
   output      logic [iopq_pkg::KEY_BITS-1:0]     rsp_key_out,
   output      logic [iopq_pkg::PAYLOAD_BITS-1:0] rsp_payload_out
);
   import iopq_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   iopq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .action     (req_action),
      .dp_status  (dp_status),
      .cmd        (dp_cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_status (rsp_status)
   );

   iopq_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (dp_cmd),
      .key_in      (req_key_in),
      .payload_in  (req_payload_in),
      .status      (dp_status),
      .key_out     (rsp_key_out),
      .payload_out (rsp_payload_out)
   );

endmodule

`default_nettype wire

>>> rtl/iopq_datapath.sv
// Datapath of the priority queue: a sorted shift-register of entries,
// the entry count and the result registers. Depends on iopq_pkg.
`default_nettype none

module iopq_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire iopq_pkg::dp_cmd_type              cmd,
   input  wire logic [iopq_pkg::KEY_BITS-1:0]     key_in,
   input  wire logic [iopq_pkg::PAYLOAD_BITS-1:0] payload_in,
   output      iopq_pkg::dp_status_type           status,
   output      logic [iopq_pkg::KEY_BITS-1:0]     key_out,
   output      logic [iopq_pkg::PAYLOAD_BITS-1:0] payload_out
);
   import iopq_pkg::*;

   logic [KEY_BITS-1:0]     cell_key_ff [DEPTH];
   logic [KEY_BITS-1:0]     cell_key_in [DEPTH];
   logic [PAYLOAD_BITS-1:0] cell_pay_ff [DEPTH];
   logic [PAYLOAD_BITS-1:0] cell_pay_in [DEPTH];
   logic [DEPTH-1:0]        greater;
   logic [COUNT_BITS-1:0]   count_ff;
   logic [COUNT_BITS-1:0]   count_in;
   logic [KEY_BITS-1:0]     rsp_key_ff;
   logic [KEY_BITS-1:0]     rsp_key_in;
   logic [PAYLOAD_BITS-1:0] rsp_pay_ff;
   logic [PAYLOAD_BITS-1:0] rsp_pay_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == COUNT_BITS'(DEPTH));

   // Each cell compares its own key against the new one. Because the cells
   // are sorted, the set of cells holding a greater key is a prefix.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         greater[i] = (COUNT_BITS'(i) < count_ff) && (cell_key_ff[i] > key_in);
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_key_in[i] = cell_key_ff[i];
         cell_pay_in[i] = cell_pay_ff[i];
         if (cmd.push) begin
            if (!greater[i]) begin
               if (i == 0 || greater[(i == 0) ? 0 : i - 1]) begin
                  cell_key_in[i] = key_in;
                  cell_pay_in[i] = payload_in;
               end else begin
                  cell_key_in[i] = cell_key_ff[(i == 0) ? 0 : i - 1];
                  cell_pay_in[i] = cell_pay_ff[(i == 0) ? 0 : i - 1];
               end
            end
         end else if (cmd.pop && i < DEPTH - 1) begin
            cell_key_in[i] = cell_key_ff[(i < DEPTH - 1) ? i + 1 : i];
            cell_pay_in[i] = cell_pay_ff[(i < DEPTH - 1) ? i + 1 : i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_comb begin
      rsp_key_in = rsp_key_ff;
      rsp_pay_in = rsp_pay_ff;
      if (cmd.load_rsp) begin
         rsp_key_in = cmd.show_head ? cell_key_ff[0] : '0;
         rsp_pay_in = cmd.show_head ? cell_pay_ff[0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_key_ff[i] <= cell_key_in[i];
         cell_pay_ff[i] <= cell_pay_in[i];
      end
      rsp_key_ff <= rsp_key_in;
      rsp_pay_ff <= rsp_pay_in;
   end

   assign key_out     = rsp_key_ff;
   assign payload_out = rsp_pay_ff;

endmodule

`default_nettype wire

>>> rtl/iopq_ctrl.sv
// Controller of the priority queue: decodes each request into datapath
// commands and sequences the result strobe and status. Depends on iopq_pkg.
`default_nettype none

module iopq_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [1:0]              action,
   input  wire iopq_pkg::dp_status_type dp_status,
   output      iopq_pkg::dp_cmd_type    cmd,
   output      logic                    busy,
   output      logic                    rsp_strobe,
   output      logic [1:0]              rsp_status
);
   import iopq_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;
   logic [1:0]    status_ff;
   logic [1:0]    status_in;
   logic          accept;
   logic          is_put;
   logic          is_get;

   // A new item is taken every cycle; the result of the previous one is
   // shown while the next is being worked on.
   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign is_put = (action == ACT_PUT);
   // Only the ACT_GET code is a get; the unused code acts as a peek.
   assign is_get = (action == ACT_GET);

   always_comb begin
      cmd.push      = accept && is_put && !dp_status.full;
      cmd.pop       = accept && is_get && !dp_status.empty;
      cmd.load_rsp  = accept;
      cmd.show_head = !is_put && !dp_status.empty;

      status_in = status_ff;
      if (accept) begin
         if (is_put) begin
            status_in = dp_status.full ? ST_FULL : ST_OK;
         end else begin
            status_in = dp_status.empty ? ST_EMPTY : ST_OK;
         end
      end

      case (state_ff)
         CTL_IDLE: begin
            state_in = accept ? CTL_RESPOND : CTL_IDLE;
         end
         CTL_RESPOND: begin
            state_in = accept ? CTL_RESPOND : CTL_IDLE;
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= CTL_IDLE;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   assign rsp_strobe = (state_ff == CTL_RESPOND);
   assign rsp_status = status_ff;

endmodule

`default_nettype wire
